// ===== hdl/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types and constants of the session query dispatcher.
// ----------------------------------------------------------------------------
package sqd_pkg;

  localparam int unsigned SID_W      = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned ENTRY_W    = 4;
  localparam int unsigned WORDS_W    = 10;
  localparam int unsigned VALUES_W   = 14;
  localparam int unsigned PEND_W     = 32;
  localparam int unsigned BYTES_W    = 64;
  localparam int unsigned FPQ_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  // bytes per 512-bit word and 32-bit values per word, as shifts
  localparam int unsigned WORD_SHIFT  = 6;
  localparam int unsigned VALUE_SHIFT = 4;

  localparam logic [FPQ_W-1:0] DEFAULT_FPQ = 16'd128;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_TABLE_FULL = 2'd1;
  localparam status_t ST_FINISHED  = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_EXPECTED_BYTES = 1'd0;
  localparam cfg_idx_t REG_FLOATS_PER_QRY = 1'd1;

endpackage

// ===== hdl/sqd_in_if.sv =====
// ----------------------------------------------------------------------------
// sqd_in_if
// Header channel: one received packet header per beat.
// ----------------------------------------------------------------------------
interface sqd_in_if;
  logic                      valid;
  logic                      ready;
  logic [sqd_pkg::SID_W-1:0] sid;
  logic [sqd_pkg::LEN_W-1:0] pkt_bytes;

  modport source(output valid, output sid, output pkt_bytes, input ready);
  modport sink(input valid, input sid, input pkt_bytes, output ready);
endinterface

// ===== hdl/sqd_out_if.sv =====
// ----------------------------------------------------------------------------
// sqd_out_if
// Result channel: one dispatch result per header.
// ----------------------------------------------------------------------------
interface sqd_out_if;
  logic                        valid;
  logic                        ready;
  logic [sqd_pkg::ENTRY_W-1:0] slot_idx;
  logic                        is_new_session;
  logic                        query_ready;
  logic [sqd_pkg::SID_W-1:0]   ready_sid;
  logic [sqd_pkg::WORDS_W-1:0] data_words;
  sqd_pkg::status_t            status;
  logic                        finished;

  modport source(output valid, output slot_idx, output is_new_session,
                 output query_ready, output ready_sid, output data_words,
                 output status, output finished, input ready);
  modport sink(input valid, input slot_idx, input is_new_session,
               input query_ready, input ready_sid, input data_words,
               input status, input finished, output ready);
endinterface

// ===== hdl/sqd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sqd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sqd_cfg_if;
  logic                           valid;
  logic                           ready;
  sqd_pkg::cfg_idx_t              index;
  logic [sqd_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/session_query_dispatcher.sv =====
// ----------------------------------------------------------------------------
// session_query_dispatcher
// Session table lookup and allocation, per-session value counting with
// query ready notices, and received byte total with finished flag.
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  in_hdr    in   sid, pkt_bytes
//  out_res   out  entry, new flag, ready notice, word count, status, finished
//  cfg_wr    in   register index, write data (always ready)
//
//  a header passes three steps: accept/compare, slot select and counter
//  read, counter update; the next header is accepted in the update cycle,
//  so a new header overlaps the last one's update unless the update stalls.
//  rst_n is synchronous; the session id table and counter memory are not
//  cleared, counter entries read as zero until first written.
//  a full result register stalls the update cycle until out_res is taken.
// ----------------------------------------------------------------------------
module session_query_dispatcher #(
  parameter int unsigned SESSIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  sqd_in_if.sink      in_hdr,
  sqd_out_if.source   out_res,
  sqd_cfg_if.sink     cfg_wr
);

  localparam int unsigned SLOT_W = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned CNT_W  = $clog2(SESSIONS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  logic [1:0] state_r, state_nxt;

  // configuration
  logic [sqd_pkg::BYTES_W-1:0] exp_bytes_r;
  logic [sqd_pkg::FPQ_W-1:0]   fpq_r;

  // session state
  logic [sqd_pkg::SID_W-1:0]   sid_tab [SESSIONS];
  logic [CNT_W-1:0]            used_r;
  logic [SESSIONS-1:0]         pend_vld_r;
  logic [sqd_pkg::PEND_W-1:0]  pend_mem [SESSIONS];
  logic [sqd_pkg::BYTES_W-1:0] rx_bytes_r;
  logic                        done_r;

  // header in flight
  logic [sqd_pkg::SID_W-1:0]   sid_r;
  logic [sqd_pkg::LEN_W-1:0]   len_r;
  logic [SESSIONS-1:0]         hit_r;
  logic [SLOT_W-1:0]           slot_r;
  logic                        is_new_r;
  sqd_pkg::status_t            status_r;
  logic [sqd_pkg::PEND_W-1:0]  pend_rd_r;
  logic                        pend_rd_vld_r;
  logic [sqd_pkg::BYTES_W-1:0] rx_sum_r;

  // result register
  logic                         out_vld_r;
  logic [sqd_pkg::ENTRY_W-1:0]  o_entry_r;
  logic                         o_new_r;
  logic                         o_qry_r;
  logic [sqd_pkg::SID_W-1:0]    o_sid_r;
  logic [sqd_pkg::WORDS_W-1:0]  o_words_r;
  sqd_pkg::status_t             o_status_r;
  logic                         o_fin_r;

  logic in_acc, out_free, wr_go;
  logic [SESSIONS-1:0] hit_nxt;

  // slot select
  logic                   hit_any;
  logic [SLOT_W-1:0]      hit_slot;
  logic [SLOT_W-1:0]      sel_slot;
  logic                   sel_new;
  sqd_pkg::status_t       sel_status;
  logic [sqd_pkg::BYTES_W:0] rx_add;

  // counter update
  logic [sqd_pkg::WORDS_W-1:0]  words;
  logic [sqd_pkg::VALUES_W-1:0] values;
  logic [sqd_pkg::PEND_W-1:0]   pend_cur;
  logic [sqd_pkg::PEND_W:0]     pend_add;
  logic [sqd_pkg::PEND_W-1:0]   pend_sat;
  logic                         qry_rdy;
  logic [sqd_pkg::PEND_W-1:0]   pend_new;
  logic                         done_nxt;

  assign out_free     = !out_vld_r || out_res.ready;
  assign wr_go        = (state_r == S_WR) && out_free;
  assign in_hdr.ready = (state_r == S_IDLE) || wr_go;
  assign in_acc       = in_hdr.valid && in_hdr.ready;
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_RD;
      S_RD:   state_nxt = S_WR;
      S_WR: begin
        if (wr_go) state_nxt = in_acc ? S_RD : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // id compare against slots in use
  always_comb begin
    for (int i = 0; i < SESSIONS; i++) begin
      hit_nxt[i] = (CNT_W'(i) < used_r) && (sid_tab[i] == in_hdr.sid);
    end
  end

  always_comb begin
    hit_any  = |hit_r;
    hit_slot = '0;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if (hit_r[i]) hit_slot = SLOT_W'(i);
    end
    sel_slot   = hit_slot;
    sel_new    = 1'b0;
    sel_status = sqd_pkg::ST_OK;
    if (done_r) begin
      sel_status = sqd_pkg::ST_FINISHED;
    end else if (!hit_any) begin
      if (used_r < CNT_W'(SESSIONS)) begin
        sel_slot = SLOT_W'(used_r);
        sel_new  = 1'b1;
      end else begin
        sel_status = sqd_pkg::ST_TABLE_FULL;
      end
    end
    rx_add = {1'b0, rx_bytes_r} + (sqd_pkg::BYTES_W + 1)'(len_r);
  end

  always_comb begin
    words    = len_r[sqd_pkg::LEN_W-1:sqd_pkg::WORD_SHIFT];
    values   = {words, {sqd_pkg::VALUE_SHIFT{1'b0}}};
    pend_cur = pend_rd_vld_r ? pend_rd_r : '0;
    pend_add = {1'b0, pend_cur} + (sqd_pkg::PEND_W + 1)'(values);
    pend_sat = pend_add[sqd_pkg::PEND_W] ? '1 : pend_add[sqd_pkg::PEND_W-1:0];
    qry_rdy  = pend_sat >= sqd_pkg::PEND_W'(fpq_r);
    pend_new = qry_rdy ? (pend_sat - sqd_pkg::PEND_W'(fpq_r)) : pend_sat;
    done_nxt = done_r;
    if (status_r == sqd_pkg::ST_OK && rx_sum_r >= exp_bytes_r) done_nxt = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_bytes_r <= '0;
      fpq_r       <= sqd_pkg::DEFAULT_FPQ;
      used_r      <= '0;
      pend_vld_r  <= '0;
      rx_bytes_r  <= '0;
      done_r      <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          sqd_pkg::REG_EXPECTED_BYTES: exp_bytes_r <= cfg_wr.data;
          sqd_pkg::REG_FLOATS_PER_QRY: fpq_r <= cfg_wr.data[sqd_pkg::FPQ_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_RD && sel_new) used_r <= used_r + 1'b1;
      if (wr_go) begin
        if (status_r == sqd_pkg::ST_OK) begin
          pend_vld_r[slot_r] <= 1'b1;
          rx_bytes_r         <= rx_sum_r;
        end
        done_r <= done_nxt;
      end
      if (wr_go) begin
        out_vld_r <= 1'b1;
      end else if (out_res.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // id table, counter memory and datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sid_r <= in_hdr.sid;
      len_r <= in_hdr.pkt_bytes;
      hit_r <= hit_nxt;
    end
    if (state_r == S_RD) begin
      if (sel_new) sid_tab[sel_slot] <= sid_r;
      slot_r        <= sel_slot;
      is_new_r      <= sel_new;
      status_r      <= sel_status;
      pend_rd_r     <= pend_mem[sel_slot];
      pend_rd_vld_r <= pend_vld_r[sel_slot];
      rx_sum_r      <= rx_add[sqd_pkg::BYTES_W] ? '1 : rx_add[sqd_pkg::BYTES_W-1:0];
    end
    if (wr_go && status_r == sqd_pkg::ST_OK) pend_mem[slot_r] <= pend_new;
    if (wr_go) begin
      o_entry_r  <= (status_r == sqd_pkg::ST_OK) ? sqd_pkg::ENTRY_W'(slot_r) : '0;
      o_new_r    <= is_new_r;
      o_qry_r    <= (status_r == sqd_pkg::ST_OK) && qry_rdy;
      o_sid_r    <= ((status_r == sqd_pkg::ST_OK) && qry_rdy) ? sid_r : '0;
      o_words_r  <= words;
      o_status_r <= status_r;
      o_fin_r    <= done_nxt;
    end
  end

  assign out_res.valid          = out_vld_r;
  assign out_res.slot_idx       = o_entry_r;
  assign out_res.is_new_session = o_new_r;
  assign out_res.query_ready    = o_qry_r;
  assign out_res.ready_sid      = o_sid_r;
  assign out_res.data_words     = o_words_r;
  assign out_res.status         = o_status_r;
  assign out_res.finished       = o_fin_r;

endmodule
